/* hw/rtl/acpu_pkg.sv */
// ----------------------------------------------------------------------------
// acpu_pkg
// Shared types, codes and decode helpers of the accumulator execute unit.
// ----------------------------------------------------------------------------
`default_nettype none

package acpu_pkg;

  // Byte memory size; addresses wrap at this power of two.
  localparam int unsigned MEM_BYTES = 65536;
  localparam int unsigned ADDR_W    = $clog2(MEM_BYTES);

  typedef enum logic [1:0] {
    REQ_EXEC  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_MODE  = 2'd1,
    STAT_STORE_IMM = 2'd2,
    STAT_BAD_OP    = 2'd3
  } status_e;

  localparam logic [1:0] MODE_IMM = 2'd0;
  localparam logic [1:0] MODE_DIR = 2'd1;

  // Instruction codes; from NOTA up, even codes act on A and odd codes on X.
  localparam logic [5:0] MN_BR       = 6'd4;
  localparam logic [5:0] MN_BRLE     = 6'd5;
  localparam logic [5:0] MN_BRLT     = 6'd6;
  localparam logic [5:0] MN_BREQ     = 6'd7;
  localparam logic [5:0] MN_BRNE     = 6'd8;
  localparam logic [5:0] MN_BRGE     = 6'd9;
  localparam logic [5:0] MN_BRGT     = 6'd10;
  localparam logic [5:0] MN_NOTA     = 6'd14;
  localparam logic [5:0] MN_NEGA     = 6'd16;
  localparam logic [5:0] MN_NEGX     = 6'd17;
  localparam logic [5:0] MN_ADDA     = 6'd46;
  localparam logic [5:0] MN_SUBA     = 6'd48;
  localparam logic [5:0] MN_ANDA     = 6'd50;
  localparam logic [5:0] MN_ORA      = 6'd52;
  localparam logic [5:0] MN_CPA      = 6'd54;
  localparam logic [5:0] MN_LDX      = 6'd57;
  localparam logic [5:0] MN_LDBYTEA  = 6'd58;
  localparam logic [5:0] MN_LDBYTEX  = 6'd59;
  localparam logic [5:0] MN_STA      = 6'd60;
  localparam logic [5:0] MN_STX      = 6'd61;
  localparam logic [5:0] MN_STBYTEA  = 6'd62;

  typedef struct packed {
    logic [15:0] acc;
    logic [15:0] idx;
    logic [15:0] pc;
    logic        neg;
    logic        zero;
  } arch_state_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] acc;
    logic [15:0] idx;
    logic [15:0] pc;
    logic        neg;
    logic        zero;
    logic [7:0]  rbyte;
  } exec_res_t;

  // Memory traffic that one request needs.
  typedef struct packed {
    logic rd_byte;
    logic rd_word;
    logic wr_byte;
    logic wr_word;
  } mem_plan_t;

  function automatic mem_plan_t mem_plan(logic [1:0] req, logic [5:0] mn, logic [1:0] mode);
    mem_plan_t p;
    logic      dir;
    dir = (req == REQ_EXEC) && (mode == MODE_DIR);
    p.rd_word = dir && (mn >= MN_ADDA) && (mn <= MN_LDX);
    p.rd_byte = (dir && (mn >= MN_LDBYTEA) && (mn <= MN_LDBYTEX)) || (req == REQ_READ);
    p.wr_word = dir && (mn >= MN_STA) && (mn <= MN_STX);
    p.wr_byte = (dir && (mn >= MN_STBYTEA)) || (req == REQ_WRITE);
    return p;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/accumulator_cpu_execute_unit.sv */
// ----------------------------------------------------------------------------
// accumulator_cpu_execute_unit
// Execute unit of a 16-bit accumulator machine with a byte memory.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload
//  s_axis   in         tuser: req_type; tdata: mnemonic, opnd_mode,
//                      operand_spec, write_byte
//  m_axis   out        tuser: status; tdata: accumulator_out, index_out,
//                      pc_out, neg_out, zero_out, read_byte
//
//  A request without a memory read, a byte write and STBYTE commit from idle.
//  A byte read (read request, direct LDBYTE) passes through RD1, a direct ST
//  through WR2 and a direct word operand through RD1 and RD2; the single memory port sets each.
//  The result sits in an output register; a new request is taken only when
//  the unit is idle and that register is empty or drained in the same cycle.
//  Reset clears the machine registers and flags; the byte memory is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module accumulator_cpu_execute_unit
  import acpu_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // mnemonic, opnd_mode, operand_spec, write_byte
  input  wire logic [1:0]  s_axis_tuser,  // req_type
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,  // accumulator_out, index_out, pc_out,
                                          // neg_out, zero_out, read_byte, zero pad
  output logic [1:0]       m_axis_tuser   // status
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD1,
    S_RD2,
    S_WR2
  } state_e;

  state_e      state_q, state_d;
  arch_state_t arch_q;
  exec_res_t   out_q;
  logic        out_valid_q;

  logic [1:0]  req_q;
  logic [5:0]  mn_q;
  logic [1:0]  mode_q;
  logic [15:0] spec_q;
  logic        rd_word_q;
  logic [7:0]  hi_q;

  logic [1:0]  in_req;
  logic [5:0]  in_mn;
  logic [1:0]  in_mode;
  logic [15:0] in_spec;
  logic [7:0]  in_wbyte;
  logic        in_accept;
  mem_plan_t   plan_in;
  logic [15:0] in_reg;
  logic [15:0] q_reg;

  logic              mem_en;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [7:0]        mem_wdata;
  logic [7:0]        mem_rdata;
  logic [ADDR_W-1:0] next_addr;

  logic        commit;
  logic        use_in;
  exec_res_t   res;

  assign in_req   = s_axis_tuser;
  assign in_mn    = s_axis_tdata[5:0];
  assign in_mode  = s_axis_tdata[7:6];
  assign in_spec  = s_axis_tdata[23:8];
  assign in_wbyte = s_axis_tdata[31:24];

  assign s_axis_tready = (state_q == S_IDLE) && (!out_valid_q || m_axis_tready);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign plan_in       = mem_plan(in_req, in_mn, in_mode);

  assign in_reg    = in_mn[0] ? arch_q.idx : arch_q.acc;
  assign q_reg     = mn_q[0] ? arch_q.idx : arch_q.acc;
  assign next_addr = spec_q[ADDR_W-1:0] + ADDR_W'(1);
  assign use_in    = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = in_spec[ADDR_W-1:0];
    mem_wdata = 8'd0;
    commit    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          if (plan_in.rd_byte || plan_in.rd_word) begin
            mem_en  = 1'b1;
            state_d = S_RD1;
          end else if (plan_in.wr_word) begin
            // Big-endian store: high byte first, low byte next cycle.
            mem_en    = 1'b1;
            mem_we    = 1'b1;
            mem_wdata = in_reg[15:8];
            state_d   = S_WR2;
          end else begin
            commit = 1'b1;
            if (plan_in.wr_byte) begin
              mem_en    = 1'b1;
              mem_we    = 1'b1;
              mem_wdata = (in_req == REQ_WRITE) ? in_wbyte : in_reg[7:0];
            end
          end
        end
      end
      S_RD1: begin
        if (rd_word_q) begin
          mem_en   = 1'b1;
          mem_addr = next_addr;
          state_d  = S_RD2;
        end else begin
          commit  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_RD2: begin
        commit  = 1'b1;
        state_d = S_IDLE;
      end
      S_WR2: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = next_addr;
        mem_wdata = q_reg[7:0];
        commit    = 1'b1;
        state_d   = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  acpu_ram #(
    .WIDTH (8),
    .DEPTH (MEM_BYTES)
  ) u_mem (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  acpu_alu u_alu (
    .req_i          (use_in ? in_req  : req_q),
    .mnemonic_i     (use_in ? in_mn   : mn_q),
    .opnd_mode_i    (use_in ? in_mode : mode_q),
    .operand_spec_i (use_in ? in_spec : spec_q),
    .mem_word_i     ({hi_q, mem_rdata}),
    .mem_byte_i     (mem_rdata),
    .state_i        (arch_q),
    .res_o          (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      arch_q      <= '0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        out_valid_q <= 1'b1;
        arch_q.acc  <= res.acc;
        arch_q.idx  <= res.idx;
        arch_q.pc   <= res.pc;
        arch_q.neg  <= res.neg;
        arch_q.zero <= res.zero;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request fields, operand byte and result payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q     <= in_req;
      mn_q      <= in_mn;
      mode_q    <= in_mode;
      spec_q    <= in_spec;
      rd_word_q <= plan_in.rd_word;
    end
    if (state_q == S_RD1) begin
      hi_q <= mem_rdata;
    end
    if (commit) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {6'd0, out_q.rbyte, out_q.zero, out_q.neg,
                          out_q.pc, out_q.idx, out_q.acc};

endmodule

`default_nettype wire

/* hw/rtl/acpu_ram.sv */
// ----------------------------------------------------------------------------
// acpu_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module acpu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem_q[addr_i];
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/acpu_alu.sv */
// ----------------------------------------------------------------------------
// acpu_alu
// Executes one request against the register state and the fetched operand.
// ----------------------------------------------------------------------------
`default_nettype none

module acpu_alu
  import acpu_pkg::*;
(
  input  wire logic [1:0]  req_i,
  input  wire logic [5:0]  mnemonic_i,
  input  wire logic [1:0]  opnd_mode_i,
  input  wire logic [15:0] operand_spec_i,
  input  wire logic [15:0] mem_word_i,
  input  wire logic [7:0]  mem_byte_i,
  input  wire arch_state_t state_i,
  output exec_res_t        res_o
);

  logic [15:0] reg_v;
  logic [15:0] opnd;
  logic [15:0] diff;
  logic [15:0] val;
  logic        wr_reg;
  logic        take;

  assign reg_v = mnemonic_i[0] ? state_i.idx : state_i.acc;
  assign opnd  = (opnd_mode_i == MODE_IMM) ? operand_spec_i : mem_word_i;
  assign diff  = reg_v - opnd;

  always_comb begin
    res_o.status = STAT_OK;
    res_o.acc    = state_i.acc;
    res_o.idx    = state_i.idx;
    res_o.pc     = state_i.pc;
    res_o.neg    = state_i.neg;
    res_o.zero   = state_i.zero;
    res_o.rbyte  = 8'd0;
    val          = 16'd0;
    wr_reg       = 1'b0;
    take         = 1'b0;

    case (req_i)
      REQ_EXEC: begin
        if ((mnemonic_i >= MN_BR) && (mnemonic_i <= MN_BRGT)) begin
          if (opnd_mode_i > MODE_DIR) begin
            res_o.status = STAT_BAD_MODE;
          end else begin
            case (mnemonic_i)
              MN_BR:   take = 1'b1;
              MN_BRLE: take = state_i.neg | state_i.zero;
              MN_BRLT: take = state_i.neg;
              MN_BREQ: take = state_i.zero;
              MN_BRNE: take = ~state_i.zero;
              MN_BRGE: take = ~state_i.neg;
              default: take = ~state_i.neg & ~state_i.zero;
            endcase
            if (take) begin
              res_o.pc = operand_spec_i;
            end
          end
        end else if ((mnemonic_i >= MN_NOTA) && (mnemonic_i <= MN_NEGX)) begin
          // NOT and NEG work on the register alone and ignore the mode.
          val    = (mnemonic_i >= MN_NEGA) ? (~reg_v + 16'd1) : ~reg_v;
          wr_reg = 1'b1;
        end else if (mnemonic_i >= MN_STA) begin
          // The memory side of a store is handled by the sequencer.
          if (opnd_mode_i == MODE_IMM) begin
            res_o.status = STAT_STORE_IMM;
          end else if (opnd_mode_i != MODE_DIR) begin
            res_o.status = STAT_BAD_MODE;
          end
        end else if (mnemonic_i >= MN_ADDA) begin
          if (opnd_mode_i > MODE_DIR) begin
            res_o.status = STAT_BAD_MODE;
          end else if (mnemonic_i >= MN_LDBYTEA) begin
            val    = {reg_v[15:8],
                      (opnd_mode_i == MODE_IMM) ? operand_spec_i[7:0] : mem_byte_i};
            wr_reg = 1'b1;
          end else begin
            case ({mnemonic_i[5:1], 1'b0})
              MN_ADDA: begin
                val    = reg_v + opnd;
                wr_reg = 1'b1;
              end
              MN_SUBA: begin
                val    = diff;
                wr_reg = 1'b1;
              end
              MN_ANDA: begin
                val    = reg_v & opnd;
                wr_reg = 1'b1;
              end
              MN_ORA: begin
                val    = reg_v | opnd;
                wr_reg = 1'b1;
              end
              MN_CPA: begin
                res_o.neg  = diff[15];
                res_o.zero = (diff == 16'd0);
              end
              default: begin
                val    = opnd;
                wr_reg = 1'b1;
              end
            endcase
          end
        end else begin
          res_o.status = STAT_BAD_OP;
        end
      end
      REQ_READ: res_o.rbyte = mem_byte_i;
      default: ;
    endcase

    if (wr_reg) begin
      if (mnemonic_i[0]) begin
        res_o.idx = val;
      end else begin
        res_o.acc = val;
      end
      res_o.neg  = val[15];
      res_o.zero = (val == 16'd0);
    end
  end

endmodule

`default_nettype wire

/* sim/accumulator_cpu_execute_unit_tb.sv */
// ----------------------------------------------------------------------------
// accumulator_cpu_execute_unit_tb
// Self-checking bench for the accumulator execute unit. A short table of
// directed requests covers reset values, extremes, every operation and all
// error codes. It is followed by random instruction and memory traffic under
// three idle patterns and one long output stall. Every result is compared
// field by field against a hand-worked value or a behavioral model in the bench.
// ----------------------------------------------------------------------------
module accumulator_cpu_execute_unit_tb
  import acpu_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Codes that the package leaves out.
  localparam logic [5:0] MN_UNUSED  = 6'd0;
  localparam logic [5:0] MN_NOTX    = 6'd15;
  localparam logic [5:0] MN_ADDX    = 6'd47;
  localparam logic [5:0] MN_SUBX    = 6'd49;
  localparam logic [5:0] MN_ANDX    = 6'd51;
  localparam logic [5:0] MN_ORX     = 6'd53;
  localparam logic [5:0] MN_CPX     = 6'd55;
  localparam logic [5:0] MN_LDA     = 6'd56;
  localparam logic [5:0] MN_STBYTEX = 6'd63;
  localparam logic [1:0] MODE_BAD   = 2'd2;
  localparam logic [1:0] MODE_BAD_HI = 2'd3;

  localparam int unsigned DIRECTED_N  = 25;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned MAX_CYCLES  = 400000;
  localparam logic [15:0] WRAP_ADDR   = 16'hFFFF;
  localparam logic [15:0] EDGE_VALS [5] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0001};

  typedef struct packed {
    req_e        req;
    logic [5:0]  mn;
    logic [1:0]  mode;
    logic [15:0] spec;
    logic [7:0]  wbyte;
  } cpu_req_t;

  typedef struct packed {
    cpu_req_t  rq;
    logic      typed;
    exec_res_t want;
  } plan_row_t;

  // Rows with typed set carry a result worked out by hand; the rest are
  // predicted. The word store at the top of memory makes 0xFFFF and 0x0000
  // readable, which the random part relies on.
  localparam plan_row_t PLAN [DIRECTED_N] = '{
    '{'{REQ_NONE, MN_UNUSED, MODE_IMM, 16'hFFFF, 8'hFF}, 1'b1,
      '{STAT_OK, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 8'h00}},
    '{'{REQ_EXEC, MN_LDA, MODE_IMM, 16'h8000, 8'h00}, 1'b1,
      '{STAT_OK, 16'h8000, 16'h0000, 16'h0000, 1'b1, 1'b0, 8'h00}},
    '{'{REQ_EXEC, MN_LDX, MODE_IMM, 16'hFFFF, 8'h00}, 1'b1,
      '{STAT_OK, 16'h8000, 16'hFFFF, 16'h0000, 1'b1, 1'b0, 8'h00}},
    '{'{REQ_EXEC, MN_STA, MODE_DIR, 16'hFFFF, 8'h00}, 1'b1,
      '{STAT_OK, 16'h8000, 16'hFFFF, 16'h0000, 1'b1, 1'b0, 8'h00}},
    '{'{REQ_EXEC, MN_STA, MODE_IMM, 16'h1234, 8'h00}, 1'b1,
      '{STAT_STORE_IMM, 16'h8000, 16'hFFFF, 16'h0000, 1'b1, 1'b0, 8'h00}},
    '{'{REQ_READ, MN_UNUSED, MODE_IMM, 16'hFFFF, 8'h00}, 1'b1,
      '{STAT_OK, 16'h8000, 16'hFFFF, 16'h0000, 1'b1, 1'b0, 8'h80}},
    '{'{REQ_WRITE, MN_UNUSED, MODE_IMM, 16'h0001, 8'hFF}, 1'b1,
      '{STAT_OK, 16'h8000, 16'hFFFF, 16'h0000, 1'b1, 1'b0, 8'h00}},
    '{'{REQ_EXEC, MN_ADDA, MODE_DIR, 16'hFFFF, 8'h00}, 1'b1,
      '{STAT_OK, 16'h0000, 16'hFFFF, 16'h0000, 1'b0, 1'b1, 8'h00}},
    '{'{REQ_EXEC, MN_BREQ, MODE_IMM, 16'hFFFF, 8'h00}, 1'b1,
      '{STAT_OK, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 8'h00}},
    '{'{REQ_EXEC, MN_BR, MODE_BAD, 16'h0000, 8'h00}, 1'b1,
      '{STAT_BAD_MODE, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 8'h00}},
    '{'{REQ_EXEC, MN_UNUSED, MODE_IMM, 16'h0000, 8'h00}, 1'b1,
      '{STAT_BAD_OP, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 8'h00}},
    '{'{REQ_EXEC, MN_STBYTEX, MODE_DIR, 16'h0002, 8'h00}, 1'b0, '0},
    '{'{REQ_EXEC, MN_LDBYTEA, MODE_DIR, 16'h0001, 8'h00}, 1'b0, '0},
    '{'{REQ_EXEC, MN_LDBYTEX, MODE_IMM, 16'h12AB, 8'h00}, 1'b0, '0},
    '{'{REQ_EXEC, MN_SUBX, MODE_IMM, 16'h0001, 8'h00}, 1'b0, '0},
    '{'{REQ_EXEC, MN_ANDA, MODE_DIR, 16'h0000, 8'h00}, 1'b0, '0},
    '{'{REQ_EXEC, MN_ORX, MODE_IMM, 16'h00F0, 8'h00}, 1'b0, '0},
    '{'{REQ_EXEC, MN_CPA, MODE_IMM, 16'h8000, 8'h00}, 1'b0, '0},
    '{'{REQ_EXEC, MN_NOTA, MODE_BAD_HI, 16'h5555, 8'h00}, 1'b0, '0},
    '{'{REQ_EXEC, MN_NEGX, MODE_BAD, 16'hAAAA, 8'h00}, 1'b0, '0},
    '{'{REQ_EXEC, MN_BRLE, MODE_IMM, 16'h0100, 8'h00}, 1'b0, '0},
    '{'{REQ_EXEC, MN_BRLT, MODE_IMM, 16'h0200, 8'h00}, 1'b0, '0},
    '{'{REQ_EXEC, MN_BRGE, MODE_DIR, 16'h0300, 8'h00}, 1'b0, '0},
    '{'{REQ_EXEC, MN_BRGT, MODE_IMM, 16'h7FFF, 8'h00}, 1'b0, '0},
    '{'{REQ_EXEC, MN_BRNE, MODE_IMM, 16'h0001, 8'h00}, 1'b0, '0}
  };

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;  // mnemonic, opnd_mode, operand_spec, write_byte
  logic [1:0]  s_axis_tuser  = REQ_NONE;  // req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;  // accumulator_out, index_out, pc_out, neg_out,
                              // zero_out, read_byte, zero pad
  logic [1:0]  m_axis_tuser;  // status

  accumulator_cpu_execute_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  // Machine state as the bench sees it.
  logic [15:0] acc_m;
  logic [15:0] idx_m;
  logic [15:0] pc_m;
  logic        neg_m;
  logic        zero_m;
  logic [7:0]  ram_m [0:MEM_BYTES-1];
  bit          ram_ok [0:MEM_BYTES-1];
  logic [15:0] written_q [$];

  exec_res_t   expected_q [$];
  int unsigned err_cnt       = 0;
  int unsigned cycle_cnt     = 0;
  int unsigned send_idle_pct = 0;
  int unsigned sink_idle_pct = 0;
  logic        sink_hold     = 1'b0;
  event        start_hold;

  function automatic void mem_store(logic [15:0] addr, logic [7:0] val);
    ram_m[addr] = val;
    if (!ram_ok[addr]) begin
      ram_ok[addr] = 1'b1;
      written_q.push_back(addr);
    end
  endfunction

  // Applies one request to the state and returns the result it must produce.
  function automatic exec_res_t model_step(cpu_req_t r);
    exec_res_t   res;
    logic [15:0] reg_v;
    logic [15:0] opnd;
    logic [15:0] val;
    logic [15:0] nxt;
    logic [1:0]  st;
    logic [7:0]  rb;
    logic        wr_reg;
    logic        take;
    st     = STAT_OK;
    rb     = 8'h00;
    wr_reg = 1'b0;
    val    = '0;
    nxt    = r.spec + 16'd1;
    reg_v  = r.mn[0] ? idx_m : acc_m;
    case (r.req)
      REQ_WRITE: mem_store(r.spec, r.wbyte);
      REQ_READ:  rb = ram_m[r.spec];
      REQ_EXEC: begin
        if (r.mn >= MN_BR && r.mn <= MN_BRGT) begin
          if (r.mode > MODE_DIR) begin
            st = STAT_BAD_MODE;
          end else begin
            case (r.mn)
              MN_BR:   take = 1'b1;
              MN_BRLE: take = neg_m | zero_m;
              MN_BRLT: take = neg_m;
              MN_BREQ: take = zero_m;
              MN_BRNE: take = !zero_m;
              MN_BRGE: take = !neg_m;
              default: take = !neg_m && !zero_m;
            endcase
            if (take) pc_m = r.spec;
          end
        end else if (r.mn >= MN_NOTA && r.mn <= MN_NEGX) begin
          // NOT and NEG ignore the addressing mode entirely.
          val = ~reg_v;
          if (r.mn >= MN_NEGA) val = val + 16'd1;
          wr_reg = 1'b1;
        end else if (r.mn >= MN_STA) begin
          if (r.mode == MODE_IMM) begin
            st = STAT_STORE_IMM;
          end else if (r.mode != MODE_DIR) begin
            st = STAT_BAD_MODE;
          end else if (r.mn < MN_STBYTEA) begin
            mem_store(r.spec, reg_v[15:8]);
            mem_store(nxt, reg_v[7:0]);
          end else begin
            mem_store(r.spec, reg_v[7:0]);
          end
        end else if (r.mn >= MN_ADDA) begin
          if (r.mode > MODE_DIR) begin
            st = STAT_BAD_MODE;
          end else if (r.mn >= MN_LDBYTEA) begin
            val = {reg_v[15:8], (r.mode == MODE_IMM) ? r.spec[7:0] : ram_m[r.spec]};
            wr_reg = 1'b1;
          end else begin
            opnd   = (r.mode == MODE_IMM) ? r.spec : {ram_m[r.spec], ram_m[nxt]};
            wr_reg = 1'b1;
            case ({r.mn[5:1], 1'b0})
              MN_ADDA: val = reg_v + opnd;
              MN_SUBA: val = reg_v - opnd;
              MN_ANDA: val = reg_v & opnd;
              MN_ORA:  val = reg_v | opnd;
              MN_CPA: begin
                val    = reg_v - opnd;
                wr_reg = 1'b0;
                neg_m  = val[15];
                zero_m = (val == 16'h0000);
              end
              default: val = opnd;
            endcase
          end
        end else begin
          st = STAT_BAD_OP;
        end
        if (wr_reg) begin
          if (r.mn[0]) idx_m = val;
          else acc_m = val;
          neg_m  = val[15];
          zero_m = (val == 16'h0000);
        end
      end
      default: ;
    endcase
    res.status = st;
    res.acc    = acc_m;
    res.idx    = idx_m;
    res.pc     = pc_m;
    res.neg    = neg_m;
    res.zero   = zero_m;
    res.rbyte  = rb;
    return res;
  endfunction

  // Picks an address whose byte (and the next one for a word) was written.
  function automatic logic [15:0] pick_readable(bit need_word);
    logic [15:0] a;
    for (int i = 0; i < 16; i++) begin
      a = written_q[$urandom_range(written_q.size() - 1)];
      if (!need_word || ram_ok[a + 16'd1]) return a;
    end
    return WRAP_ADDR;
  endfunction

  function automatic logic [15:0] pick_store_addr();
    int unsigned k;
    logic [15:0] a;
    k = $urandom_range(9);
    a = written_q[$urandom_range(written_q.size() - 1)];
    if (k < 4) return a;
    if (k < 6) return $urandom_range(1) ? a + 16'd1 : a - 16'd1;
    return 16'($urandom_range(16'hFFFF));
  endfunction

  function automatic cpu_req_t random_request();
    cpu_req_t    r;
    int unsigned sel;
    int unsigned k;
    sel     = $urandom_range(99);
    r.req   = REQ_EXEC;
    r.mn    = 6'($urandom_range(63));
    r.mode  = 2'($urandom_range(3));
    r.spec  = 16'($urandom_range(16'hFFFF));
    r.wbyte = 8'($urandom_range(255));
    if (sel < 14) begin
      r.req  = REQ_WRITE;
      r.spec = pick_store_addr();
    end else if (sel < 24) begin
      r.req  = REQ_READ;
      r.spec = pick_readable(1'b0);
    end else if (sel < 27) begin
      r.req = REQ_NONE;
    end else begin
      if ($urandom_range(99) < 92) begin
        k = $urandom_range(28);
        if (k < 7) r.mn = MN_BR + 6'(k);
        else if (k < 11) r.mn = MN_NOTA + 6'(k - 7);
        else r.mn = MN_ADDA + 6'(k - 11);
      end
      k = $urandom_range(99);
      if (k < 45) r.mode = MODE_IMM;
      else if (k < 92) r.mode = MODE_DIR;
      else r.mode = MODE_BAD | 2'($urandom_range(1));
      if (r.mode == MODE_DIR) begin
        if (r.mn >= MN_ADDA && r.mn <= MN_LDX) r.spec = pick_readable(1'b1);
        else if (r.mn == MN_LDBYTEA || r.mn == MN_LDBYTEX) r.spec = pick_readable(1'b0);
        else if (r.mn >= MN_STA) r.spec = pick_store_addr();
      end else if (r.mode == MODE_IMM && $urandom_range(99) < 15) begin
        r.spec = EDGE_VALS[$urandom_range(4)];
      end
    end
    return r;
  endfunction

  // Offers one request, waits for it to be taken, then records the result
  // it must produce and optionally leaves the bus idle for a while.
  task automatic push_request(input cpu_req_t rq, input logic typed, input exec_res_t want);
    exec_res_t pred;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {rq.wbyte, rq.spec, rq.mode, rq.mn};
    s_axis_tuser  <= rq.req;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pred = model_step(rq);
    expected_q.push_back(typed ? want : pred);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic wait_drained();
    if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= rst_ni && !sink_hold && ($urandom_range(99) >= sink_idle_pct);
  end

  // Long output stall, so that the unit fills up and blocks its input.
  initial begin
    forever begin
      @(start_hold);
      @(posedge clk_i);
      sink_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      sink_hold <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : check_result
    exec_res_t got;
    exec_res_t want;
    string     bad;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status = m_axis_tuser;
      got.acc    = m_axis_tdata[15:0];
      got.idx    = m_axis_tdata[31:16];
      got.pc     = m_axis_tdata[47:32];
      got.neg    = m_axis_tdata[48];
      got.zero   = m_axis_tdata[49];
      got.rbyte  = m_axis_tdata[57:50];
      if (expected_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("result with no request pending: %h", got);
      end else begin
        want = expected_q.pop_front();
        bad  = "";
        if (got.status !== want.status) bad = {bad, " status"};
        if (got.acc !== want.acc) bad = {bad, " acc"};
        if (got.idx !== want.idx) bad = {bad, " idx"};
        if (got.pc !== want.pc) bad = {bad, " pc"};
        if (got.neg !== want.neg) bad = {bad, " neg"};
        if (got.zero !== want.zero) bad = {bad, " zero"};
        if (got.rbyte !== want.rbyte) bad = {bad, " rbyte"};
        if (bad != "") begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("mismatch in%s", bad);
            $display("  want st=%0d a=%h x=%h pc=%h n=%b z=%b rb=%h", want.status, want.acc,
                     want.idx, want.pc, want.neg, want.zero, want.rbyte);
            $display("  got  st=%0d a=%h x=%h pc=%h n=%b z=%b rb=%h", got.status, got.acc,
                     got.idx, got.pc, got.neg, got.zero, got.rbyte);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == MAX_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    acc_m  = '0;
    idx_m  = '0;
    pc_m   = '0;
    neg_m  = 1'b0;
    zero_m = 1'b0;
    send_idle_pct = 29;
    sink_idle_pct = 62;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIRECTED_N; i++) push_request(PLAN[i].rq, PLAN[i].typed, PLAN[i].want);
    wait_drained();

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin send_idle_pct = 29; sink_idle_pct = 62; end
        1: begin send_idle_pct = 62; sink_idle_pct = 29; end
        default: begin send_idle_pct = 0; sink_idle_pct = 0; end
      endcase
      for (int i = 0; i < ((p == 2) ? 170 : 190); i++) begin
        if (p == 2 && i == 40) -> start_hold;
        push_request(random_request(), 1'b0, '0);
      end
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    if (err_cnt == 0 && expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
